// ----- design/rcsfp_pkg.sv -----
// Shared types and constants for the servo frame parser.
// Holds the sequencer states, frame phases, result kinds and the ALU request/response structs.
// No dependencies.
`timescale 1ns / 1ps

package rcsfp_pkg;

    // Frame layout constants
    localparam int unsigned OVERHEAD      = 3;
    localparam logic [3:0]  SERVO_CMD     = 4'd4;
    localparam int unsigned SERVO_PAYLOAD = 29;
    localparam logic [15:0] SUM_INIT      = 16'hFFFF;

    // Port widths fixed by the interface
    localparam int unsigned CFG_IDX_W = 1;
    localparam int unsigned CH_IDX_W  = 4;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GAP_TIMEOUT = 1'b0,
        REG_TIME_WRAP   = 1'b1
    } cfg_reg_t;

    typedef enum logic [1:0] {
        KIND_CHAN = 2'd0,
        KIND_GOOD = 2'd1,
        KIND_BAD  = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        PH_LEN   = 2'd0,
        PH_DATA  = 2'd1,
        PH_CK_LO = 2'd2,
        PH_CK_HI = 2'd3
    } phase_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_GAP_SUB,
        S_GAP_WRAP,
        S_GAP_TO,
        S_GAP_MAX,
        S_GAP_MIN,
        S_PARSE,
        S_CH_RDLO,
        S_CH_RDHI,
        S_CH_MIN,
        S_CH_MAX,
        S_OUT
    } state_t;

    typedef enum logic {
        ALU_ADD = 1'b0,
        ALU_SUB = 1'b1
    } alu_op_t;

    typedef struct packed {
        alu_op_t     op;
        logic [31:0] a;
        logic [31:0] b;
    } alu_req_t;

    typedef struct packed {
        logic [31:0] res;
        logic        cout;
    } alu_rsp_t;

endpackage

// ----- design/rc_servo_frame_parser_unit.sv -----
// Servo frame parser: byte-serial frame parsing with gap statistics and channel tracking.
// Depends on rcsfp_pkg, rcsfp_alu and rcsfp_ram.
// Flow: each byte is taken in S_IDLE and, when stamped, passes S_GAP_SUB, S_GAP_WRAP (only when
// the stamp wraps), S_GAP_TO, S_GAP_MAX and S_GAP_MIN before S_PARSE; a frame's last byte then
// goes to S_OUT, or on a servo frame through S_CH_RDLO, S_CH_RDHI, S_CH_MIN, S_CH_MAX and S_OUT
// per channel. No new byte is taken until the result side has taken the byte's last result.
// Reset (synchronous, aresetn low) clears counters, channel tables and parser state at once.
`timescale 1ns / 1ps

module rc_servo_frame_parser_unit #(
    parameter int unsigned CHANNELS        = 14,
    parameter int unsigned FRAME_BYTES_MAX = 32
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // configuration
    input  logic                               cfg_wr_en,
    input  logic [rcsfp_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [31:0]                        cfg_wdata,
    // input requests
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [7:0]                         s_rx_byte,
    input  logic [31:0]                        s_arrival_time,
    // result requests
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [1:0]                         m_kind,
    output logic [rcsfp_pkg::CH_IDX_W-1:0]     m_channel_index,
    output logic [15:0]                        m_channel_value,
    output logic [15:0]                        m_channel_min,
    output logic [15:0]                        m_channel_max,
    output logic [31:0]                        m_channel_updates,
    output logic                               m_last,
    output logic [31:0]                        m_good_frames,
    output logic [31:0]                        m_bad_frames,
    output logic [31:0]                        m_timeouts,
    output logic [31:0]                        m_min_gap,
    output logic [31:0]                        m_max_gap
);

    localparam int unsigned LEN_W  = $clog2(FRAME_BYTES_MAX + 1);
    localparam int unsigned ADDR_W = $clog2(FRAME_BYTES_MAX);
    localparam int unsigned CH_AW  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam logic [rcsfp_pkg::CH_IDX_W-1:0] LAST_CH =
        rcsfp_pkg::CH_IDX_W'(CHANNELS - 1);
    localparam logic [8:0]       LEN_BYTE_MAX = 9'(FRAME_BYTES_MAX);
    localparam logic [LEN_W-1:0] LEN_MAX      = LEN_W'(FRAME_BYTES_MAX - rcsfp_pkg::OVERHEAD);
    localparam logic [LEN_W-1:0] SERVO_LEN    = LEN_W'(rcsfp_pkg::SERVO_PAYLOAD);

    rcsfp_pkg::state_t state_reg, state_next;
    rcsfp_pkg::phase_t phase_reg;
    rcsfp_pkg::kind_t  kind_reg;

    logic [31:0] gap_timeout_reg;
    logic [31:0] time_wrap_reg;

    logic [LEN_W-1:0] pos_reg;
    logic [LEN_W-1:0] len_reg;
    logic [15:0]      sum_reg;
    logic [31:0]      prev_time_reg;
    logic [31:0]      good_cnt_reg;
    logic [31:0]      bad_cnt_reg;
    logic [31:0]      timeout_cnt_reg;
    logic [31:0]      gap_min_reg;
    logic [31:0]      gap_max_reg;
    logic [rcsfp_pkg::CH_IDX_W-1:0] ch_reg;
    logic             last_reg;

    logic [15:0] chan_val_reg [CHANNELS];
    logic [15:0] chan_min_reg [CHANNELS];
    logic [15:0] chan_max_reg [CHANNELS];
    logic [31:0] chan_cnt_reg [CHANNELS];

    // payload registers
    logic [7:0]  byte_reg;
    logic [31:0] time_reg;
    logic [31:0] gap_reg;
    logic [7:0]  check_lo_reg;
    logic [3:0]  cmd_reg;
    logic [7:0]  lo_reg;
    logic [15:0] val_reg;

    rcsfp_pkg::alu_req_t alu_req;
    rcsfp_pkg::alu_rsp_t alu_rsp;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [ADDR_W-1:0] ram_raddr;
    logic [ADDR_W-1:0] rd_lo_addr;
    logic [7:0]        ram_rdata;

    logic              s_accept;
    logic              len_ok;
    logic              frame_good;
    logic              servo_frame;
    logic [LEN_W-1:0]  pos_inc;
    logic              data_done;
    logic [CH_AW-1:0]  ch_idx;
    logic [15:0]       chan_val;
    logic              is_chan;

    rcsfp_alu u_alu (
        .req (alu_req),
        .rsp (alu_rsp)
    );

    rcsfp_ram #(
        .WIDTH (8),
        .DEPTH (FRAME_BYTES_MAX)
    ) u_payload_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (byte_reg),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Decode frame conditions
    assign s_accept    = s_valid & s_ready;
    assign len_ok      = ({1'b0, byte_reg} <= LEN_BYTE_MAX) &&
                         (byte_reg > 8'(rcsfp_pkg::OVERHEAD));
    assign frame_good  = (sum_reg == {byte_reg, check_lo_reg});
    assign servo_frame = (cmd_reg == rcsfp_pkg::SERVO_CMD) && (len_reg == SERVO_LEN);
    assign pos_inc     = pos_reg + 1'b1;
    assign data_done   = (pos_inc >= len_reg);
    assign ch_idx      = ch_reg[CH_AW-1:0];
    assign chan_val    = {ram_rdata, lo_reg};
    assign rd_lo_addr  = ADDR_W'({ch_reg, 1'b1});

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            rcsfp_pkg::S_IDLE: begin
                if (s_accept) begin
                    state_next = (s_arrival_time != 32'd0) ? rcsfp_pkg::S_GAP_SUB
                                                           : rcsfp_pkg::S_PARSE;
                end
            end
            rcsfp_pkg::S_GAP_SUB: begin
                state_next = alu_rsp.cout ? rcsfp_pkg::S_GAP_WRAP : rcsfp_pkg::S_GAP_TO;
            end
            rcsfp_pkg::S_GAP_WRAP: state_next = rcsfp_pkg::S_GAP_TO;
            rcsfp_pkg::S_GAP_TO:   state_next = rcsfp_pkg::S_GAP_MAX;
            rcsfp_pkg::S_GAP_MAX:  state_next = rcsfp_pkg::S_GAP_MIN;
            rcsfp_pkg::S_GAP_MIN:  state_next = rcsfp_pkg::S_PARSE;
            rcsfp_pkg::S_PARSE: begin
                if (phase_reg == rcsfp_pkg::PH_CK_HI) begin
                    state_next = (frame_good && servo_frame) ? rcsfp_pkg::S_CH_RDLO
                                                             : rcsfp_pkg::S_OUT;
                end else begin
                    state_next = rcsfp_pkg::S_IDLE;
                end
            end
            rcsfp_pkg::S_CH_RDLO: state_next = rcsfp_pkg::S_CH_RDHI;
            rcsfp_pkg::S_CH_RDHI: state_next = rcsfp_pkg::S_CH_MIN;
            rcsfp_pkg::S_CH_MIN:  state_next = rcsfp_pkg::S_CH_MAX;
            rcsfp_pkg::S_CH_MAX:  state_next = rcsfp_pkg::S_OUT;
            rcsfp_pkg::S_OUT: begin
                if (m_ready) begin
                    state_next = (kind_reg == rcsfp_pkg::KIND_CHAN && !last_reg)
                               ? rcsfp_pkg::S_CH_RDLO : rcsfp_pkg::S_IDLE;
                end
            end
            default: state_next = rcsfp_pkg::S_IDLE;
        endcase
    end

    // Sequencer outputs: handshake, ALU operands, RAM control
    always_comb begin
        s_ready   = (state_reg == rcsfp_pkg::S_IDLE);
        m_valid   = (state_reg == rcsfp_pkg::S_OUT);
        ram_we    = (state_reg == rcsfp_pkg::S_PARSE) && (phase_reg == rcsfp_pkg::PH_DATA);
        ram_waddr = pos_reg[ADDR_W-1:0];
        ram_raddr = (state_reg == rcsfp_pkg::S_CH_RDHI) ? rd_lo_addr + 1'b1 : rd_lo_addr;
        alu_req.op = rcsfp_pkg::ALU_SUB;
        alu_req.a  = '0;
        alu_req.b  = '0;
        case (state_reg)
            rcsfp_pkg::S_GAP_SUB: begin
                alu_req.a = time_reg;
                alu_req.b = prev_time_reg;
            end
            rcsfp_pkg::S_GAP_WRAP: begin
                alu_req.op = rcsfp_pkg::ALU_ADD;
                alu_req.a  = gap_reg;
                alu_req.b  = time_wrap_reg;
            end
            rcsfp_pkg::S_GAP_TO: begin
                alu_req.a = gap_timeout_reg;
                alu_req.b = gap_reg;
            end
            rcsfp_pkg::S_GAP_MAX: begin
                alu_req.a = gap_max_reg;
                alu_req.b = gap_reg;
            end
            rcsfp_pkg::S_GAP_MIN: begin
                alu_req.a = gap_reg;
                alu_req.b = gap_min_reg;
            end
            rcsfp_pkg::S_PARSE: begin
                alu_req.a = (phase_reg == rcsfp_pkg::PH_LEN) ? {16'd0, rcsfp_pkg::SUM_INIT}
                                                             : {16'd0, sum_reg};
                alu_req.b = {24'd0, byte_reg};
            end
            rcsfp_pkg::S_CH_MIN: begin
                alu_req.a = {16'd0, chan_val};
                alu_req.b = {16'd0, chan_min_reg[ch_idx]};
            end
            rcsfp_pkg::S_CH_MAX: begin
                alu_req.a = {16'd0, chan_max_reg[ch_idx]};
                alu_req.b = {16'd0, val_reg};
            end
            default: begin
                alu_req.op = rcsfp_pkg::ALU_SUB;
            end
        endcase
    end

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= rcsfp_pkg::S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Control, statistics and channel tables
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gap_timeout_reg <= '0;
            time_wrap_reg   <= '0;
            phase_reg       <= rcsfp_pkg::PH_LEN;
            kind_reg        <= rcsfp_pkg::KIND_CHAN;
            last_reg        <= 1'b0;
            pos_reg         <= '0;
            len_reg         <= '0;
            sum_reg         <= '0;
            prev_time_reg   <= '0;
            good_cnt_reg    <= '0;
            bad_cnt_reg     <= '0;
            timeout_cnt_reg <= '0;
            gap_min_reg     <= '1;
            gap_max_reg     <= '0;
            ch_reg          <= '0;
            for (int i = 0; i < CHANNELS; i++) begin
                chan_val_reg[i] <= '0;
                chan_min_reg[i] <= '1;
                chan_max_reg[i] <= '0;
                chan_cnt_reg[i] <= '0;
            end
        end else begin
            // Take configuration writes
            if (cfg_wr_en) begin
                case (rcsfp_pkg::cfg_reg_t'(cfg_index))
                    rcsfp_pkg::REG_GAP_TIMEOUT: gap_timeout_reg <= cfg_wdata;
                    rcsfp_pkg::REG_TIME_WRAP:   time_wrap_reg   <= cfg_wdata;
                    default: ;
                endcase
            end
            case (state_reg)
                // Count a timeout and resynchronize
                rcsfp_pkg::S_GAP_TO: begin
                    if (alu_rsp.cout) begin
                        timeout_cnt_reg <= timeout_cnt_reg + 1'b1;
                        phase_reg       <= rcsfp_pkg::PH_LEN;
                    end
                end
                rcsfp_pkg::S_GAP_MAX: begin
                    if (alu_rsp.cout) begin
                        gap_max_reg <= gap_reg;
                    end
                end
                rcsfp_pkg::S_GAP_MIN: begin
                    if (alu_rsp.cout) begin
                        gap_min_reg <= gap_reg;
                    end
                end
                // Advance the frame parser by one byte
                rcsfp_pkg::S_PARSE: begin
                    prev_time_reg <= time_reg;
                    case (phase_reg)
                        rcsfp_pkg::PH_LEN: begin
                            if (len_ok) begin
                                pos_reg   <= '0;
                                len_reg   <= LEN_W'(byte_reg - 8'(rcsfp_pkg::OVERHEAD));
                                sum_reg   <= alu_rsp.res[15:0];
                                phase_reg <= rcsfp_pkg::PH_DATA;
                            end
                        end
                        rcsfp_pkg::PH_DATA: begin
                            pos_reg <= pos_inc;
                            sum_reg <= alu_rsp.res[15:0];
                            if (data_done) begin
                                phase_reg <= rcsfp_pkg::PH_CK_LO;
                            end
                        end
                        rcsfp_pkg::PH_CK_LO: begin
                            phase_reg <= rcsfp_pkg::PH_CK_HI;
                        end
                        default: begin
                            phase_reg <= rcsfp_pkg::PH_LEN;
                            if (frame_good) begin
                                good_cnt_reg <= good_cnt_reg + 1'b1;
                                if (servo_frame) begin
                                    ch_reg <= '0;
                                end else begin
                                    kind_reg <= rcsfp_pkg::KIND_GOOD;
                                    last_reg <= 1'b1;
                                end
                            end else begin
                                bad_cnt_reg <= bad_cnt_reg + 1'b1;
                                kind_reg    <= rcsfp_pkg::KIND_BAD;
                                last_reg    <= 1'b1;
                            end
                        end
                    endcase
                end
                // Update the channel value and minimum
                rcsfp_pkg::S_CH_MIN: begin
                    chan_val_reg[ch_idx] <= chan_val;
                    if (alu_rsp.cout) begin
                        chan_min_reg[ch_idx] <= chan_val;
                    end
                end
                // Update maximum and count, then present the channel
                rcsfp_pkg::S_CH_MAX: begin
                    if (alu_rsp.cout) begin
                        chan_max_reg[ch_idx] <= val_reg;
                    end
                    chan_cnt_reg[ch_idx] <= chan_cnt_reg[ch_idx] + 1'b1;
                    kind_reg <= rcsfp_pkg::KIND_CHAN;
                    last_reg <= (ch_reg == LAST_CH);
                end
                // Step to the next channel once a request is taken
                rcsfp_pkg::S_OUT: begin
                    if (m_ready && kind_reg == rcsfp_pkg::KIND_CHAN && !last_reg) begin
                        ch_reg <= ch_reg + 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    // Payload capture, no reset needed
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            byte_reg <= s_rx_byte;
            time_reg <= s_arrival_time;
        end
        if (state_reg == rcsfp_pkg::S_GAP_SUB || state_reg == rcsfp_pkg::S_GAP_WRAP) begin
            gap_reg <= alu_rsp.res;
        end
        if (state_reg == rcsfp_pkg::S_PARSE) begin
            if (phase_reg == rcsfp_pkg::PH_CK_LO) begin
                check_lo_reg <= byte_reg;
            end
            if (phase_reg == rcsfp_pkg::PH_DATA && pos_reg == '0) begin
                cmd_reg <= byte_reg[7:4];
            end
        end
        if (state_reg == rcsfp_pkg::S_CH_RDHI) begin
            lo_reg <= ram_rdata;
        end
        if (state_reg == rcsfp_pkg::S_CH_MIN) begin
            val_reg <= chan_val;
        end
    end

    // Drive the result request
    assign is_chan           = (kind_reg == rcsfp_pkg::KIND_CHAN);
    assign m_kind            = kind_reg;
    assign m_channel_index   = is_chan ? ch_reg : '0;
    assign m_channel_value   = is_chan ? chan_val_reg[ch_idx] : '0;
    assign m_channel_min     = is_chan ? chan_min_reg[ch_idx] : '0;
    assign m_channel_max     = is_chan ? chan_max_reg[ch_idx] : '0;
    assign m_channel_updates = is_chan ? chan_cnt_reg[ch_idx] : '0;
    assign m_last            = last_reg;
    assign m_good_frames     = good_cnt_reg;
    assign m_bad_frames      = bad_cnt_reg;
    assign m_timeouts        = timeout_cnt_reg;
    assign m_min_gap         = gap_min_reg;
    assign m_max_gap         = gap_max_reg;

    // Input and output sides are never open together
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input ready while a result is pending");

    // More channel results follow a non-final one before the next byte
    a_burst_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !m_last) |=> !s_ready)
        else $error("input reopened inside a channel burst");

    // Frame-level results are always the final one for the byte
    a_single_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_kind != rcsfp_pkg::KIND_CHAN) |-> m_last)
        else $error("frame result without last");

    // A channel update step always ends in a presented channel result
    a_chan_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == rcsfp_pkg::S_CH_MAX) |=> (m_valid && m_kind == rcsfp_pkg::KIND_CHAN))
        else $error("channel update not presented");

    // Payload length stays in range while inside a frame
    a_len_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg != rcsfp_pkg::PH_LEN) |-> (len_reg != '0 && len_reg <= LEN_MAX))
        else $error("payload length out of range");

endmodule

// ----- design/rcsfp_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing; used for the frame payload store.
`timescale 1ns / 1ps

module rcsfp_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- design/rcsfp_alu.sv -----
// Shared 32-bit add/subtract unit with carry/borrow out.
// Depends on rcsfp_pkg for the request and response structs.
`timescale 1ns / 1ps

module rcsfp_alu (
    input  rcsfp_pkg::alu_req_t req,
    output rcsfp_pkg::alu_rsp_t rsp
);

    logic [32:0] wide;

    // Add or subtract with one extra bit for carry or borrow
    always_comb begin
        case (req.op)
            rcsfp_pkg::ALU_ADD: wide = {1'b0, req.a} + {1'b0, req.b};
            rcsfp_pkg::ALU_SUB: wide = {1'b0, req.a} - {1'b0, req.b};
            default:            wide = '0;
        endcase
    end

    assign rsp.res  = wide[31:0];
    assign rsp.cout = wide[32];

endmodule

// ----- bench/tb.sv -----
// Self-checking bench for the servo frame parser: length, checksum, servo and timing cases,
// back-pressure and random frame traffic, all scored against an in-bench parser copy.
// Depends on rcsfp_pkg and rc_servo_frame_parser_unit.
`timescale 1ns / 1ps

module tb;
    import rcsfp_pkg::*;

    localparam int unsigned CHANNELS        = 14;
    localparam int unsigned FRAME_BYTES_MAX = 32;
    localparam int unsigned FULL_FRAME      = 255;
    localparam int unsigned SETTLE_CYCLES   = 40;
    localparam int unsigned HOLD_CYCLES     = 500;
    localparam int unsigned CYCLE_LIMIT     = 400000;

    // receiver stall patterns
    localparam int RDY_ALWAYS = 0;
    localparam int RDY_RANDOM = 1;
    localparam int RDY_MOSTLY = 2;
    localparam int RDY_SPARSE = 3;

    typedef struct packed {
        kind_t       kind;
        logic [3:0]  ch_index;
        logic [15:0] value;
        logic [15:0] vmin;
        logic [15:0] vmax;
        logic [31:0] updates;
        logic        last;
        logic [31:0] good;
        logic [31:0] bad;
        logic [31:0] tmo;
        logic [31:0] gmin;
        logic [31:0] gmax;
    } report_t;

    logic        aclk           = 1'b0;
    logic        aresetn        = 1'b0;
    logic        cfg_wr_en      = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [31:0] cfg_wdata      = '0;
    logic        s_valid        = 1'b0;
    logic        s_ready;
    logic [7:0]  s_rx_byte      = '0;
    logic [31:0] s_arrival_time = '0;
    logic        m_valid;
    logic        m_ready        = 1'b0;
    logic [1:0]  m_kind;
    logic [CH_IDX_W-1:0] m_channel_index;
    logic [15:0] m_channel_value;
    logic [15:0] m_channel_min;
    logic [15:0] m_channel_max;
    logic [31:0] m_channel_updates;
    logic        m_last;
    logic [31:0] m_good_frames;
    logic [31:0] m_bad_frames;
    logic [31:0] m_timeouts;
    logic [31:0] m_min_gap;
    logic [31:0] m_max_gap;

    rc_servo_frame_parser_unit #(
        .CHANNELS       (CHANNELS),
        .FRAME_BYTES_MAX(FRAME_BYTES_MAX)
    ) u_top (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_rx_byte        (s_rx_byte),
        .s_arrival_time   (s_arrival_time),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_kind           (m_kind),
        .m_channel_index  (m_channel_index),
        .m_channel_value  (m_channel_value),
        .m_channel_min    (m_channel_min),
        .m_channel_max    (m_channel_max),
        .m_channel_updates(m_channel_updates),
        .m_last           (m_last),
        .m_good_frames    (m_good_frames),
        .m_bad_frames     (m_bad_frames),
        .m_timeouts       (m_timeouts),
        .m_min_gap        (m_min_gap),
        .m_max_gap        (m_max_gap)
    );

    // 2 ns clock
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Parser copy: registers and state
    // ------------------------------------------------------------------
    logic [31:0] m_gap_timeout = '0;
    logic [31:0] m_time_wrap   = '0;
    phase_t      m_phase       = PH_LEN;
    logic [4:0]  m_pos         = '0;
    logic [4:0]  m_len         = '0;
    logic [15:0] m_sum         = '0;
    logic [15:0] m_check       = '0;
    logic [7:0]  m_store [FRAME_BYTES_MAX];
    logic [31:0] m_prev_time   = '0;
    logic [15:0] m_ch_value [CHANNELS] = '{default: 16'h0000};
    logic [15:0] m_ch_min   [CHANNELS] = '{default: 16'hFFFF};
    logic [15:0] m_ch_max   [CHANNELS] = '{default: 16'h0000};
    logic [31:0] m_ch_count [CHANNELS] = '{default: 32'h0};
    logic [31:0] m_good      = '0;
    logic [31:0] m_bad       = '0;
    logic [31:0] m_tmo_cnt   = '0;
    logic [31:0] m_gap_min   = 32'hFFFF_FFFF;
    logic [31:0] m_gap_max   = '0;

    report_t pending_reports [$];

    // bench bookkeeping
    int unsigned errors        = 0;
    int unsigned bytes_sent    = 0;
    int unsigned n_chan_items  = 0;
    int unsigned n_good_items  = 0;
    int unsigned n_bad_items   = 0;
    int unsigned cycle_count   = 0;
    int unsigned burst_left    = 0;
    bit          hold_request  = 1'b0;

    // timestamp generator knobs
    logic [31:0] cur_time  = '0;
    int unsigned zero_pct  = 100;
    int unsigned norm_lo   = 1;
    int unsigned norm_hi   = 1;
    int unsigned jump_pct  = 0;
    logic [31:0] jump_lo   = 32'd1;
    logic [31:0] jump_span = 32'd0;
    bit          force_jump = 1'b0;

    // Advance the parser copy by one byte and queue the result items it causes
    function automatic void parse_byte(input logic [7:0] b, input logic [31:0] t);
        logic [31:0] gap;
        logic [15:0] v;
        report_t     base;
        report_t     r;
        if (t != 32'd0) begin
            if (t < m_prev_time) gap = m_time_wrap - m_prev_time + t;
            else gap = t - m_prev_time;
            if (gap > m_gap_timeout) begin
                m_tmo_cnt++;
                m_phase = PH_LEN;
            end
            if (m_gap_max < gap) m_gap_max = gap;
            if (m_gap_min > gap) m_gap_min = gap;
        end
        m_prev_time = t;

        case (m_phase)
            PH_LEN: begin
                if (b <= FRAME_BYTES_MAX && b > OVERHEAD) begin
                    m_pos   = '0;
                    m_len   = 5'(b - OVERHEAD);
                    m_sum   = SUM_INIT - 16'(b);
                    m_phase = PH_DATA;
                end
            end
            PH_DATA: begin
                m_store[m_pos] = b;
                m_pos = m_pos + 5'd1;
                m_sum = m_sum - 16'(b);
                if (m_pos >= m_len) m_phase = PH_CK_LO;
            end
            PH_CK_LO: begin
                m_check = {8'h00, b};
                m_phase = PH_CK_HI;
            end
            default: begin
                m_check[15:8] = b;
                m_phase = PH_LEN;
                if (m_check == m_sum) m_good++;
                else m_bad++;
                base      = '0;
                base.good = m_good;
                base.bad  = m_bad;
                base.tmo  = m_tmo_cnt;
                base.gmin = m_gap_min;
                base.gmax = m_gap_max;
                if (m_check != m_sum) begin
                    r = base;
                    r.kind = KIND_BAD;
                    r.last = 1'b1;
                    pending_reports.push_back(r);
                end else if (m_store[0][7:4] == SERVO_CMD && m_len == SERVO_PAYLOAD) begin
                    // update every channel first, then report them in order
                    for (int i = 0; i < CHANNELS; i++) begin
                        v = {m_store[2 + 2 * i], m_store[1 + 2 * i]};
                        m_ch_value[i] = v;
                        if (m_ch_min[i] > v) m_ch_min[i] = v;
                        if (m_ch_max[i] < v) m_ch_max[i] = v;
                        m_ch_count[i] = m_ch_count[i] + 32'd1;
                    end
                    for (int i = 0; i < CHANNELS; i++) begin
                        r = base;
                        r.kind     = KIND_CHAN;
                        r.ch_index = 4'(i);
                        r.value    = m_ch_value[i];
                        r.vmin     = m_ch_min[i];
                        r.vmax     = m_ch_max[i];
                        r.updates  = m_ch_count[i];
                        r.last     = (i == CHANNELS - 1);
                        pending_reports.push_back(r);
                    end
                end else begin
                    r = base;
                    r.kind = KIND_GOOD;
                    r.last = 1'b1;
                    pending_reports.push_back(r);
                end
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Result side: check each accepted item, then pick the next ready level
    // ------------------------------------------------------------------
    function automatic void cmp_field(input string name, input logic [31:0] exp_v,
                                      input logic [31:0] act_v);
        if (exp_v !== act_v) begin
            errors++;
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, exp_v, act_v);
        end
    endfunction

    int unsigned hold_left = 0;
    int unsigned mode_left = 0;
    int          rdy_mode  = RDY_ALWAYS;

    always @(posedge aclk) begin
        report_t want;
        if (aresetn && m_valid && m_ready) begin
            if (m_kind == KIND_CHAN) n_chan_items++;
            else if (m_kind == KIND_GOOD) n_good_items++;
            else n_bad_items++;
            if (pending_reports.size() == 0) begin
                errors++;
                $display("%0t: unexpected result: expected none, actual kind %0d channel %0d",
                         $time, m_kind, m_channel_index);
            end else begin
                want = pending_reports.pop_front();
                cmp_field("kind",            want.kind,     m_kind);
                cmp_field("channel_index",   want.ch_index, m_channel_index);
                cmp_field("channel_value",   want.value,    m_channel_value);
                cmp_field("channel_min",     want.vmin,     m_channel_min);
                cmp_field("channel_max",     want.vmax,     m_channel_max);
                cmp_field("channel_updates", want.updates,  m_channel_updates);
                cmp_field("last",            want.last,     m_last);
                cmp_field("good_frames",     want.good,     m_good_frames);
                cmp_field("bad_frames",      want.bad,      m_bad_frames);
                cmp_field("timeouts",        want.tmo,      m_timeouts);
                cmp_field("min_gap",         want.gmin,     m_min_gap);
                cmp_field("max_gap",         want.gmax,     m_max_gap);
            end
        end

        // hold off for a long stretch when asked, otherwise follow a changing pattern
        if (hold_request) begin
            hold_left    = HOLD_CYCLES;
            hold_request = 1'b0;
        end
        if (mode_left == 0) begin
            rdy_mode  = $urandom_range(RDY_ALWAYS, RDY_SPARSE);
            mode_left = $urandom_range(16, 96);
        end else begin
            mode_left--;
        end
        if (hold_left != 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            case (rdy_mode)
                RDY_ALWAYS: m_ready <= 1'b1;
                RDY_RANDOM: m_ready <= 1'($urandom_range(0, 1));
                RDY_MOSTLY: m_ready <= ($urandom_range(0, 7) != 0);
                default:    m_ready <= (mode_left % 4 == 0);
            endcase
        end
    end

    // Cycle limit
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------
    // Next arrival time: mostly small steps, sometimes zero or a long jump, wrapping at the
    // configured wrap value
    function automatic logic [31:0] next_time();
        logic [32:0] lim;
        logic [32:0] acc;
        logic [31:0] delta;
        if (!force_jump && $urandom_range(0, 99) < zero_pct) begin
            next_time = '0;
        end else begin
            if (force_jump || $urandom_range(0, 99) < jump_pct)
                delta = jump_lo + $urandom_range(0, jump_span);
            else
                delta = $urandom_range(norm_lo, norm_hi);
            force_jump = 1'b0;
            lim = (m_time_wrap == 32'd0) ? 33'h1_0000_0000 : {1'b0, m_time_wrap};
            acc = {1'b0, cur_time} + {1'b0, delta};
            if (acc >= lim) acc = acc - lim;
            cur_time  = acc[31:0];
            next_time = cur_time;
        end
    endfunction

    // Offer one byte, hold it until accepted, then idle between bursts
    task automatic send_byte(input logic [7:0] b, input logic [31:0] t);
        int unsigned idle;
        s_valid        <= 1'b1;
        s_rx_byte      <= b;
        s_arrival_time <= t;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        parse_byte(b, t);
        bytes_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            idle = $urandom_range(0, 12);
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 120)
                                                      : $urandom_range(0, 24);
            if (idle > 0) begin
                s_valid <= 1'b0;
                repeat (idle) @(posedge aclk);
            end
        end
    endtask

    // Build a frame of flen bytes (length byte, payload, checksum) and send its first keep bytes
    task automatic send_frame(input int unsigned flen, input logic [7:0] first,
                              input bit corrupt, input int unsigned keep);
        logic [7:0]  fb [$];
        logic [15:0] chk;
        logic [15:0] v;
        int unsigned plen;
        plen = flen - OVERHEAD;
        fb.push_back(8'(flen));
        fb.push_back(first);
        for (int unsigned j = 1; j < plen; j += 2) begin
            case ($urandom_range(0, 3))
                0:       v = 16'h0000;
                1:       v = 16'hFFFF;
                default: v = 16'($urandom);
            endcase
            fb.push_back(v[7:0]);
            if (j + 1 < plen) fb.push_back(v[15:8]);
        end
        chk = SUM_INIT;
        foreach (fb[k]) chk = chk - 16'(fb[k]);
        if (corrupt) chk = chk ^ (16'd1 << $urandom_range(0, 15));
        fb.push_back(chk[7:0]);
        fb.push_back(chk[15:8]);
        foreach (fb[k]) begin
            if (k < keep) send_byte(fb[k], next_time());
        end
    endtask

    // Wait until every expected item is back and the block has settled
    task automatic drain_parser();
        s_valid <= 1'b0;
        while (pending_reports.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [31:0] v);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
        case (idx)
            REG_GAP_TIMEOUT: m_gap_timeout = v;
            default:         m_time_wrap   = v;
        endcase
    endtask

    // Write both registers and retune the timestamp generator to match
    task automatic configure_phase(input logic [31:0] gap_to, input logic [31:0] wrap,
                                   input int unsigned zp, input int unsigned nlo,
                                   input int unsigned nhi, input int unsigned jp,
                                   input logic [31:0] jlo, input logic [31:0] jspan,
                                   input logic [31:0] start);
        write_reg(REG_GAP_TIMEOUT, gap_to);
        write_reg(REG_TIME_WRAP, wrap);
        zero_pct  = zp;
        norm_lo   = nlo;
        norm_hi   = nhi;
        jump_pct  = jp;
        jump_lo   = jlo;
        jump_span = jspan;
        cur_time  = start;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // Length bounds, short good frames, a checksum failure and a timeout with zero limit
    task automatic test_length_and_checksum();
        send_byte(8'd0, 32'd0);
        send_byte(8'd3, 32'd0);
        send_byte(8'd33, 32'd0);
        send_byte(8'd255, 32'd0);
        send_frame(4, 8'h4A, 1'b0, FULL_FRAME);
        send_frame(4, 8'h00, 1'b1, FULL_FRAME);
        send_frame(5, 8'hFF, 1'b0, FULL_FRAME);
        // first stamped byte times out and starts the frame itself
        zero_pct = 0;
        norm_lo  = 0;
        norm_hi  = 0;
        cur_time = 32'd4;
        send_frame(4, 8'h21, 1'b0, FULL_FRAME);
    endtask

    // Timeout mid-frame, wrap of the time source, stale time above wrap, gap equal to limit
    task automatic test_timing_cases();
        send_frame(10, 8'h40, 1'b0, 4);
        force_jump = 1'b1;
        send_frame(4, 8'h12, 1'b0, FULL_FRAME);
        cur_time = 32'd99990;
        send_frame(10, 8'h55, 1'b0, FULL_FRAME);
        send_byte(8'h00, 32'd200000);
        send_byte(8'h00, 32'd10);
        cur_time = 32'd10;
        norm_lo  = 40;
        norm_hi  = 40;
        send_frame(4, 8'h99, 1'b0, FULL_FRAME);
        norm_lo  = 1;
        norm_hi  = 40;
    endtask

    // Servo frames, and the frames that miss servo by command or by length
    task automatic test_servo_frames();
        send_frame(32, 8'h40, 1'b0, FULL_FRAME);
        send_frame(32, 8'h3F, 1'b0, FULL_FRAME);
        send_frame(12, 8'h44, 1'b0, FULL_FRAME);
    endtask

    // Stall the result side while a servo frame and then a short frame keep coming,
    // so the input backs up
    task automatic test_backpressure();
        int unsigned saved_jump;
        saved_jump   = jump_pct;
        jump_pct     = 0;
        hold_request = 1'b1;
        burst_left   = 200;
        send_frame(32, {SERVO_CMD, 4'($urandom)}, 1'b0, FULL_FRAME);
        send_frame(4, 8'h4C, 1'b0, FULL_FRAME);
        jump_pct     = saved_jump;
    endtask

    // Mostly well-formed frames with random content, plus broken frames and noise
    task automatic test_random_traffic(input int unsigned n_bytes);
        int unsigned start;
        int unsigned pick;
        int unsigned flen;
        int unsigned nib;
        start = bytes_sent;
        while (bytes_sent - start < n_bytes) begin
            pick = $urandom_range(0, 99);
            if (pick < 15) begin
                send_frame(32, {SERVO_CMD, 4'($urandom)}, 1'b0, FULL_FRAME);
            end else if (pick < 22) begin
                nib = $urandom_range(0, 14);
                if (nib >= SERVO_CMD) nib++;
                send_frame(32, {4'(nib), 4'($urandom)}, 1'b0, FULL_FRAME);
            end else if (pick < 28) begin
                send_frame($urandom_range(4, 31), {SERVO_CMD, 4'($urandom)}, 1'b0, FULL_FRAME);
            end else if (pick < 70) begin
                send_frame($urandom_range(4, 12), 8'($urandom), 1'b0, FULL_FRAME);
            end else if (pick < 78) begin
                send_frame($urandom_range(4, 32), 8'($urandom), 1'b0, FULL_FRAME);
            end else if (pick < 86) begin
                send_frame($urandom_range(4, 32), 8'($urandom), 1'b1, FULL_FRAME);
            end else if (pick < 93) begin
                flen = $urandom_range(4, 32);
                send_frame(flen, 8'($urandom), 1'b0, $urandom_range(1, flen - 1));
            end else begin
                repeat ($urandom_range(1, 3)) send_byte(8'($urandom), next_time());
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset register values, unstamped bytes, then one stamped frame
        test_length_and_checksum();
        drain_parser();

        // tight gap limit, small wrap value
        configure_phase(32'd40, 32'd100000, 2, 1, 40, 2, 32'd41, 32'd5000, 32'd99990);
        test_timing_cases();
        test_servo_frames();
        test_backpressure();
        test_random_traffic(10);
        drain_parser();

        // no timeouts possible, wrap at the top of the range
        configure_phase(32'hFFFF_FFFF, 32'hFFFF_FFFF, 2, 1, 1000, 10,
                        32'h0100_0000, 32'hF000_0000, 32'hFFFF_FC00);
        test_random_traffic(8);
        drain_parser();

        // zero gap limit and zero wrap: only equal or zero stamps keep a frame alive
        configure_phase(32'd0, 32'd0, 30, 0, 0, 5, 32'd1, 32'd100, 32'h0000_1000);
        test_random_traffic(6);
        drain_parser();

        $display("Run covered %0d bytes over four register settings and %0d result items:",
                 bytes_sent, n_chan_items + n_good_items + n_bad_items);
        $display("  %0d channel updates, %0d other good frames, %0d checksum failures",
                 n_chan_items, n_good_items, n_bad_items);
        if (errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
